/* rtl/core/mcp_pkg.sv */
// ---------------------------------------------------------------------------
// mcp_pkg: shared types and constants of the Monte Carlo option pricer
// Configuration layout, queue entry format and a 32-bit saturation helper.
// ---------------------------------------------------------------------------
package mcp_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIKE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATURITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PUT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ANTI     = 3'd6;

    localparam logic [16:0] DF_RESET = 17'd65536;
    localparam logic [31:0] MAX32    = 32'hFFFF_FFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [31:0] forward;
        logic [31:0] strike;
        logic [17:0] volatility;
        logic [23:0] maturity;
        logic [16:0] discount;
        logic        put_not_call;
        logic        antithetic;
    } t_cfg;

    typedef struct packed {
        logic [31:0] payoff;
        logic        last;
    } t_qent;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        sat32 = (v > 64'(MAX32)) ? MAX32 : v[31:0];
    endfunction

endpackage

/* rtl/core/mc_european_option_pricer.sv */
// ---------------------------------------------------------------------------
// mc_european_option_pricer: Monte Carlo Black-76 European option pricer
// Each sample yields one or two lognormal paths; the last sample of a run
// returns discounted price, standard error and 95% half-width.
//
//  channel  dir  payload                                   handshake
//  s_axis   in   tdata[15:0] normal_sample, tlast=last     tvalid/tready
//  m_axis   out  tdata 4x32 price,err,half,paths           tvalid/tready
//  cfg      in   i_cfg_index[2:0], i_cfg_data[31:0]        i_cfg_valid/o_cfg_ready
//
//  The front works on one accepted sample at a time before it takes the next
//  (RW = (24+FRAC_BITS)/2 sqrt steps, 4 multiplies, 7 reduction steps, three states
//  per series term, scale, push, idle); antithetic mode repeats the exponent through
//  push for the second path. The back loads, squares and adds each path, and at end
//  of run performs three 64-step divisions and 32 sqrt steps.
//  Reset is synchronous; sums clear and the discount factor resets to 1.0.
//  A 4-entry payoff queue parts front and back; a stalled result holds in
//  the output register while accumulation of the next run continues.
// ---------------------------------------------------------------------------
module mc_european_option_pricer #(
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // normal_sample
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // option_price, standard_error, half_width_95, paths_used
    output logic [127:0]                   m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mcp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import mcp_pkg::*;

    t_cfg  r_cfg;
    t_qent f_entry, q_entry;
    logic  f_push, q_full, q_valid, q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.forward      <= '0;
            r_cfg.strike       <= '0;
            r_cfg.volatility   <= '0;
            r_cfg.maturity     <= '0;
            r_cfg.discount     <= DF_RESET;
            r_cfg.put_not_call <= 1'b0;
            r_cfg.antithetic   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FORWARD:  r_cfg.forward      <= i_cfg_data;
                CFG_STRIKE:   r_cfg.strike       <= i_cfg_data;
                CFG_VOL:      r_cfg.volatility   <= i_cfg_data[17:0];
                CFG_MATURITY: r_cfg.maturity     <= i_cfg_data[23:0];
                CFG_DISCOUNT: r_cfg.discount     <= i_cfg_data[16:0];
                CFG_PUT:      r_cfg.put_not_call <= i_cfg_data[0];
                CFG_ANTI:     r_cfg.antithetic   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    mcp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_sample (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_push   (f_push),
        .o_entry  (f_entry),
        .i_full   (q_full)
    );

    mcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_entry (f_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    mcp_back #(.FRAC_BITS(FRAC_BITS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_df     (r_cfg.discount),
        .i_qvalid (q_valid),
        .o_qpop   (q_pop),
        .i_entry  (q_entry),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata)
    );

endmodule

/* rtl/core/mcp_front.sv */
// ---------------------------------------------------------------------------
// mcp_front: path evaluation
// Takes one sample, forms the lognormal exponent, evaluates exp() by range
// reduction and a 12-term series, and pushes one or two payoffs.
// ---------------------------------------------------------------------------
module mcp_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mcp_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [15:0]    i_sample,
    input  logic           i_last,
    output logic           o_push,
    output mcp_pkg::t_qent o_entry,
    input  logic           i_full
);
    import mcp_pkg::*;

    localparam int TW    = 24 + FRAC_BITS;
    localparam int SW    = TW + (TW % 2);
    localparam int RW    = SW / 2;
    localparam int VW    = 18 + RW - FRAC_BITS;
    localparam int SSW   = 36 - FRAC_BITS;
    localparam int CAPW  = FRAC_BITS + 8;
    localparam int XW    = FRAC_BITS + 10;
    localparam int AW    = 37;
    localparam int CNTW  = $clog2(RW + 1);
    localparam int TERMS = 12;

    localparam logic [CAPW-1:0] CAP = {1'b1, {(CAPW-1){1'b0}}};
    localparam int X_LO_I = -64 * (2 ** FRAC_BITS);
    localparam int X_HI_I = 44 * (2 ** FRAC_BITS);
    localparam logic signed [XW-1:0] X_LO = XW'(X_LO_I);
    localparam logic signed [XW-1:0] X_HI = XW'(X_HI_I);
    localparam logic [29:0] LN2   = 30'd744261118;
    localparam logic [30:0] ONE30 = 31'h4000_0000;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQRT = 4'd1;
    localparam logic [3:0] S_MVS  = 4'd2;
    localparam logic [3:0] S_MSS  = 4'd3;
    localparam logic [3:0] S_MHV  = 4'd4;
    localparam logic [3:0] S_MM   = 4'd5;
    localparam logic [3:0] S_XF   = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_TA   = 4'd8;
    localparam logic [3:0] S_TB   = 4'd9;
    localparam logic [3:0] S_TC   = 4'd10;
    localparam logic [3:0] S_SCL  = 4'd11;
    localparam logic [3:0] S_SHF  = 4'd12;
    localparam logic [3:0] S_PUSH = 4'd13;

    // floor((2^32-1)/i); the estimate is then at most one below the quotient
    function automatic logic [31:0] recip(input logic [3:0] i);
        case (i)
            4'd1:    recip = 32'd4294967295;
            4'd2:    recip = 32'd2147483647;
            4'd3:    recip = 32'd1431655765;
            4'd4:    recip = 32'd1073741823;
            4'd5:    recip = 32'd858993459;
            4'd6:    recip = 32'd715827882;
            4'd7:    recip = 32'd613566756;
            4'd8:    recip = 32'd536870911;
            4'd9:    recip = 32'd477218588;
            4'd10:   recip = 32'd429496729;
            4'd11:   recip = 32'd390451572;
            4'd12:   recip = 32'd357913941;
            default: recip = 32'd0;
        endcase
    endfunction

    logic [3:0]             r_state;
    logic [CNTW-1:0]        r_cnt;
    logic                   r_neg, r_last, r_pass, r_xneg;
    logic [15:0]            r_mag;
    logic [SW-1:0]          r_sq_src;
    logic [RW+2:0]          r_sq_rem;
    logic [RW-1:0]          r_sq_res;
    logic [VW-1:0]          r_vst;
    logic [SSW-1:0]         r_ss;
    logic [CAPW-1:0]        r_hv, r_m;
    logic [AW-1:0]          r_xabs;
    logic [5:0]             r_q;
    logic signed [7:0]      r_k;
    logic [29:0]            r_r;
    logic [30:0]            r_term, r_p, r_qe;
    logic [31:0]            r_acc, r_ft;
    logic [60:0]            r_tprod;
    logic [63:0]            r_fprod;

    // sqrt step
    logic [RW+2:0] sq_sh, sq_trial, sq_rem_n;
    logic          sq_ge;
    // products
    logic [18+RW-1:0]       vs_prod;
    logic [35:0]            ss_prod;
    logic [SSW+23:0]        hv_prod, hv_sh;
    logic [VW+15:0]         m_prod, m_sh;
    // exponent
    logic signed [XW-1:0]   mx, hx, x;
    logic [XW-1:0]          xa;
    logic                   sel_neg;
    // reduction step
    logic [AW-1:0]          dv, xr_n;
    logic                   dv_ge;
    logic [6:0]             q_n;
    logic signed [7:0]      q8, k_n;
    logic [29:0]            r_n;
    // series
    logic [62:0]            qe_prod;
    logic [34:0]            chk;
    logic [30:0]            rm, q_fix;
    logic                   rm_ge;
    // scale
    logic signed [8:0]      sh;
    logic [31:0]            ft_n, payoff, mag_in;

    always_comb begin
        sq_sh    = {r_sq_rem[RW:0], r_sq_src[SW-1 -: 2]};
        sq_trial = {1'b0, r_sq_res, 2'b01};
        sq_ge    = (sq_sh >= sq_trial);
        sq_rem_n = sq_ge ? (sq_sh - sq_trial) : sq_sh;

        vs_prod = i_cfg.volatility * r_sq_res;
        ss_prod = i_cfg.volatility * i_cfg.volatility;
        hv_prod = r_ss * i_cfg.maturity;
        hv_sh   = hv_prod >> (FRAC_BITS + 1);
        m_prod  = r_vst * r_mag;
        m_sh    = m_prod >> 12;

        sel_neg = r_neg ^ r_pass;
        mx      = signed'({2'b00, r_m});
        hx      = signed'({2'b00, r_hv});
        x       = (sel_neg ? -mx : mx) - hx;
        xa      = x[XW-1] ? XW'(-x) : XW'(x);

        dv    = AW'(LN2) << r_cnt[2:0];
        dv_ge = (r_xabs >= dv);
        xr_n  = dv_ge ? (r_xabs - dv) : r_xabs;
        q_n   = {r_q, dv_ge};
        q8    = signed'({1'b0, q_n});
        if (!r_xneg) begin
            k_n = q8;
            r_n = xr_n[29:0];
        end else if (xr_n == '0) begin
            k_n = -q8;
            r_n = '0;
        end else begin
            k_n = -q8 - 8'sd1;
            r_n = LN2 - xr_n[29:0];
        end

        qe_prod = r_tprod[60:30] * recip(r_cnt[3:0]);
        chk     = r_qe * r_cnt[3:0];
        rm      = r_p - chk[30:0];
        rm_ge   = (rm >= 31'(r_cnt[3:0]));
        q_fix   = r_qe + 31'(rm_ge);

        sh = 9'sd30 - 9'(r_k);
        if (r_k >= 8'sd30) begin
            ft_n = MAX32;
        end else if (sh >= 9'sd64) begin
            ft_n = '0;
        end else begin
            ft_n = sat32(r_fprod >> sh[5:0]);
        end

        if (i_cfg.put_not_call) begin
            payoff = (i_cfg.strike > r_ft) ? (i_cfg.strike - r_ft) : '0;
        end else begin
            payoff = (r_ft > i_cfg.strike) ? (r_ft - i_cfg.strike) : '0;
        end

        mag_in = i_sample[15] ? (32'h0001_0000 - 32'(i_sample)) : 32'(i_sample);

        o_ready        = (r_state == S_IDLE);
        o_push         = (r_state == S_PUSH) && !i_full;
        o_entry.payoff = payoff;
        o_entry.last   = r_last && (!i_cfg.antithetic || r_pass);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_neg    <= i_sample[15];
                        r_mag    <= mag_in[15:0];
                        r_last   <= i_last;
                        r_pass   <= 1'b0;
                        r_sq_src <= SW'({i_cfg.maturity, {FRAC_BITS{1'b0}}});
                        r_sq_rem <= '0;
                        r_sq_res <= '0;
                        r_cnt    <= CNTW'(RW - 1);
                        r_state  <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_sq_src <= r_sq_src << 2;
                    r_sq_rem <= sq_rem_n;
                    r_sq_res <= {r_sq_res[RW-2:0], sq_ge};
                    r_cnt    <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_state <= S_MVS;
                end
                S_MVS: begin
                    r_vst   <= vs_prod[18+RW-1:FRAC_BITS];
                    r_state <= S_MSS;
                end
                S_MSS: begin
                    r_ss    <= ss_prod[35:FRAC_BITS];
                    r_state <= S_MHV;
                end
                S_MHV: begin
                    r_hv    <= (hv_sh > (SSW+24)'(CAP)) ? CAP : hv_sh[CAPW-1:0];
                    r_state <= S_MM;
                end
                S_MM: begin
                    r_m     <= (m_sh > (VW+16)'(CAP)) ? CAP : m_sh[CAPW-1:0];
                    r_state <= S_XF;
                end
                S_XF: begin
                    if ((i_cfg.forward == '0) || (x < X_LO)) begin
                        r_ft    <= '0;
                        r_state <= S_PUSH;
                    end else if (x > X_HI) begin
                        r_ft    <= MAX32;
                        r_state <= S_PUSH;
                    end else begin
                        r_xabs  <= AW'(xa) << (30 - FRAC_BITS);
                        r_xneg  <= x[XW-1];
                        r_q     <= '0;
                        r_cnt   <= CNTW'(6);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_xabs <= xr_n;
                    r_q    <= q_n[5:0];
                    if (r_cnt == '0) begin
                        r_k     <= k_n;
                        r_r     <= r_n;
                        r_term  <= ONE30;
                        r_acc   <= 32'(ONE30);
                        r_cnt   <= CNTW'(1);
                        r_state <= S_TA;
                    end else begin
                        r_cnt   <= r_cnt - 1'b1;
                    end
                end
                S_TA: begin
                    r_tprod <= r_term * r_r;
                    r_state <= S_TB;
                end
                S_TB: begin
                    r_p     <= r_tprod[60:30];
                    r_qe    <= qe_prod[62:32];
                    r_state <= S_TC;
                end
                S_TC: begin
                    r_term <= q_fix;
                    r_acc  <= r_acc + 32'(q_fix);
                    if (r_cnt == CNTW'(TERMS)) begin
                        r_state <= S_SCL;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_TA;
                    end
                end
                S_SCL: begin
                    r_fprod <= i_cfg.forward * r_acc;
                    r_state <= S_SHF;
                end
                S_SHF: begin
                    r_ft    <= ft_n;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_full) begin
                        if (!i_cfg.antithetic || r_pass) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pass  <= 1'b1;
                            r_state <= S_XF;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/core/mcp_queue.sv */
// ---------------------------------------------------------------------------
// mcp_queue: payoff queue
// Small FIFO between path evaluation and accumulation.
// ---------------------------------------------------------------------------
module mcp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mcp_pkg::t_qent i_entry,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output mcp_pkg::t_qent o_entry
);
    import mcp_pkg::*;

    t_qent             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              push_ok, pop_ok;

    always_comb begin
        o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
        o_valid = (r_count != '0);
        o_entry = r_mem[r_rd];
        push_ok = i_push && !o_full;
        pop_ok  = i_pop && o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) r_wr <= r_wr + 1'b1;
            if (pop_ok)  r_rd <= r_rd + 1'b1;
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_ok && !pop_ok) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not rise on push");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && !push_ok) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not fall on pop");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QCNT_W'(QUEUE_DEPTH)) |-> (r_wr == r_rd))
        else $error("queue pointers out of step");

endmodule

/* rtl/core/mcp_back.sv */
// ---------------------------------------------------------------------------
// mcp_back: accumulation and run statistics
// Sums payoffs and squares; on the last item of a run divides, takes the
// square root and scales, then clears its sums.
// ---------------------------------------------------------------------------
module mcp_back #(
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [16:0]    i_df,
    input  logic           i_qvalid,
    output logic           o_qpop,
    input  mcp_pkg::t_qent i_entry,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [127:0]   o_data
);
    import mcp_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam logic [63:0] VMAX = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS;
    localparam logic [30:0] C196 = 31'd2104533975;

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_MUL  = 4'd1;
    localparam logic [3:0] B_ADD  = 4'd2;
    localparam logic [3:0] B_DIV1 = 4'd3;
    localparam logic [3:0] B_DIV2 = 4'd4;
    localparam logic [3:0] B_M0   = 4'd5;
    localparam logic [3:0] B_M1   = 4'd6;
    localparam logic [3:0] B_VAR  = 4'd7;
    localparam logic [3:0] B_DIV3 = 4'd8;
    localparam logic [3:0] B_SQRT = 4'd9;
    localparam logic [3:0] B_PRL  = 4'd10;
    localparam logic [3:0] B_PRH  = 4'd11;
    localparam logic [3:0] B_SE   = 4'd12;
    localparam logic [3:0] B_HW   = 4'd13;
    localparam logic [3:0] B_OUT  = 4'd14;

    logic [3:0]    r_state;
    logic [31:0]   r_p;
    logic          r_last;
    logic [63:0]   r_pp, r_sum, r_sq;
    logic [CW-1:0] r_cnt, r_n;
    logic [63:0]   r_dvd, r_mean, r_msq, r_p0, r_src;
    logic [CW:0]   r_rem;
    logic [5:0]    r_step;
    logic [30:0]   r_p1;
    logic [34:0]   r_srem;
    logic [31:0]   r_sres, r_se, r_price;
    logic [48:0]   r_pl, r_ph, r_sep;
    logic [62:0]   r_hwp;
    logic          r_oval;
    logic [127:0]  r_odata;

    logic [64:0]   sum_w, sq_w;
    logic [63:0]   sum_n, sq_n;
    logic [CW-1:0] cnt_n;
    logic [CW:0]   d_sh, d_rem_n;
    logic          d_ge;
    logic [63:0]   d_dvd_n;
    logic [63:0]   p1_prod, m2, var_v, var_c;
    logic [34:0]   s_sh, s_trial, s_rem_n;
    logic          s_ge;
    logic [63:0]   price_w;
    logic [31:0]   se_c;
    logic          load;

    always_comb begin
        sum_w = {1'b0, r_sum} + 65'(r_p);
        sq_w  = {1'b0, r_sq} + 65'(r_pp >> FRAC_BITS);
        sum_n = sum_w[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_w[63:0];
        sq_n  = sq_w[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_w[63:0];
        cnt_n = (&r_cnt) ? r_cnt : r_cnt + 1'b1;

        d_sh    = {r_rem[CW-1:0], r_dvd[63]};
        d_ge    = (d_sh >= {1'b0, r_n});
        d_rem_n = d_ge ? (d_sh - {1'b0, r_n}) : d_sh;
        d_dvd_n = {r_dvd[62:0], d_ge};

        p1_prod = r_mean[31:0] * r_mean[63:32];
        // low 64 bits of mean squared, shifted down by FRAC_BITS, as the square wraps
        m2    = (r_p0 + {r_p1, 33'd0}) >> FRAC_BITS;
        var_v = (r_msq > m2) ? (r_msq - m2) : '0;
        var_c = (var_v > VMAX) ? VMAX : var_v;

        s_sh    = {r_srem[32:0], r_src[63:62]};
        s_trial = {1'b0, r_sres, 2'b01};
        s_ge    = (s_sh >= s_trial);
        s_rem_n = s_ge ? (s_sh - s_trial) : s_sh;

        price_w = 64'(r_pl) + {r_ph[31:0], 32'd0};
        se_c    = sat32(64'(r_sep) >> FRAC_BITS);

        load    = (r_state == B_OUT) && (!r_oval || i_ready);
        o_qpop  = (r_state == B_IDLE) && i_qvalid;
        o_valid = r_oval;
        o_data  = r_odata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_sum   <= '0;
            r_sq    <= '0;
            r_cnt   <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (r_oval && i_ready && !load) r_oval <= 1'b0;
            unique case (r_state) inside
                B_IDLE: begin
                    if (i_qvalid) begin
                        r_p     <= i_entry.payoff;
                        r_last  <= i_entry.last;
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_pp    <= r_p * r_p;
                    r_state <= B_ADD;
                end
                B_ADD: begin
                    r_sum <= sum_n;
                    r_sq  <= sq_n;
                    r_cnt <= cnt_n;
                    if (r_last) begin
                        r_n     <= cnt_n;
                        r_dvd   <= sum_n;
                        r_rem   <= '0;
                        r_step  <= 6'd63;
                        r_state <= B_DIV1;
                    end else begin
                        r_state <= B_IDLE;
                    end
                end
                B_DIV1, B_DIV2, B_DIV3: begin
                    if (r_step != '0) begin
                        r_dvd  <= d_dvd_n;
                        r_rem  <= d_rem_n;
                        r_step <= r_step - 1'b1;
                    end else begin
                        r_rem <= '0;
                        if (r_state == B_DIV1) begin
                            r_mean  <= d_dvd_n;
                            r_dvd   <= r_sq;
                            r_step  <= 6'd63;
                            r_state <= B_DIV2;
                        end else if (r_state == B_DIV2) begin
                            r_msq   <= d_dvd_n;
                            r_state <= B_M0;
                        end else begin
                            r_src   <= d_dvd_n;
                            r_srem  <= '0;
                            r_sres  <= '0;
                            r_step  <= 6'd31;
                            r_state <= B_SQRT;
                        end
                    end
                end
                B_M0: begin
                    r_p0    <= r_mean[31:0] * r_mean[31:0];
                    r_state <= B_M1;
                end
                B_M1: begin
                    r_p1    <= p1_prod[30:0];
                    r_state <= B_VAR;
                end
                B_VAR: begin
                    r_dvd   <= var_c << FRAC_BITS;
                    r_rem   <= '0;
                    r_step  <= 6'd63;
                    r_state <= B_DIV3;
                end
                B_SQRT: begin
                    r_src  <= r_src << 2;
                    r_srem <= s_rem_n;
                    r_sres <= {r_sres[30:0], s_ge};
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) r_state <= B_PRL;
                end
                B_PRL: begin
                    r_pl    <= r_mean[31:0] * i_df;
                    r_state <= B_PRH;
                end
                B_PRH: begin
                    r_ph    <= r_mean[63:32] * i_df;
                    r_state <= B_SE;
                end
                B_SE: begin
                    r_sep   <= r_sres * i_df;
                    r_state <= B_HW;
                end
                B_HW: begin
                    r_price <= sat32(price_w >> FRAC_BITS);
                    r_se    <= se_c;
                    r_hwp   <= se_c * C196;
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (load) begin
                        r_oval  <= 1'b1;
                        r_odata <= {sat32(64'(r_n)), sat32(64'(r_hwp >> 30)), r_se, r_price};
                        r_sum   <= '0;
                        r_sq    <= '0;
                        r_cnt   <= '0;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && !i_ready) |=> (r_oval && $stable(r_odata)))
        else $error("result dropped while stalled");

    a_clear_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_cnt == '0 && r_sum == '0 && r_sq == '0))
        else $error("sums not cleared after result");

    a_paths_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (r_n != '0))
        else $error("result with zero paths");

endmodule
